// ===== design/code_reference_scanner_assert.svh =====
// Assertion macros shared by the code reference scanner RTL.
`ifndef CODE_REFERENCE_SCANNER_ASSERT_SVH
`define CODE_REFERENCE_SCANNER_ASSERT_SVH

`ifndef ASSERT_OFF

// Checks a property at every rising clock edge outside reset.
`define SCB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("scanner assertion failed");

// Checks that a condition implies a consequence in the same cycle.
`define SCB_ASSERT_IMPL(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("scanner implication failed");

// Checks that a condition implies a consequence in the next cycle.
`define SCB_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("scanner next-cycle check failed");

`else

`define SCB_ASSERT(lbl, clk, rst, prop)
`define SCB_ASSERT_IMPL(lbl, clk, rst, cond, cons)
`define SCB_ASSERT_NEXT(lbl, clk, rst, cond, cons)

`endif

`endif

// ===== design/scb_pkg.sv =====
// Shared types and constants of the code reference scanner.
`timescale 1ns / 1ps
`default_nettype none

package scb_pkg;

   localparam int ADDR_W    = 64;
   localparam int BYTE_W    = 8;
   localparam int OPND_W    = 32;
   localparam int WIN_DEPTH = 6;
   // Cell holding the opcode of a five-byte form and of a seven-byte form.
   localparam int SHORT_TAP = 3;
   localparam int LONG_TAP  = 5;

   // Opcodes and prefix bytes.
   localparam logic [BYTE_W-1:0] OP_CALL_REL  = 8'hE8;
   localparam logic [BYTE_W-1:0] OP_JMP_REL   = 8'hE9;
   localparam logic [BYTE_W-1:0] OP_REX_W     = 8'h48;
   localparam logic [BYTE_W-1:0] OP_LEA       = 8'h8D;
   localparam logic [BYTE_W-1:0] OP_PUSH_IMM  = 8'h68;
   localparam logic [BYTE_W-1:0] OP_CALL_FAR  = 8'h9A;
   localparam logic [BYTE_W-1:0] OP_MOV_EAX   = 8'hB8;
   localparam logic [BYTE_W-1:0] OP_MOV_ECX   = 8'hB9;
   localparam logic [BYTE_W-1:0] OP_MOV_EDX   = 8'hBA;
   localparam logic [BYTE_W-1:0] OP_MOV_RM    = 8'hC7;

   // Scan kinds.
   localparam logic KIND_FUNCTION = 1'b0;
   localparam logic KIND_STRING   = 1'b1;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_TARGET  = 2'd0,
      CSR_MODE32  = 2'd1,
      CSR_KIND    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
   } cell_type;

   typedef struct packed {
      logic [ADDR_W-1:0] target_address;
      logic              mode_32bit;
      logic              scan_kind;
   } config_type;

   typedef struct packed {
      logic              short_hit;
      logic [ADDR_W-1:0] short_address;
      logic              long_hit;
      logic [ADDR_W-1:0] long_address;
   } result_type;

endpackage

`default_nettype wire

// ===== design/scb_req_if.sv =====
// Input channel carrying code bytes with their addresses.
`timescale 1ns / 1ps
`default_nettype none

interface scb_req_if;
   logic                        valid;
   logic                        ready;
   logic [scb_pkg::BYTE_W-1:0]  data_byte;
   logic [scb_pkg::ADDR_W-1:0]  byte_address;
   logic                        region_first;

   modport source (output valid, output data_byte, output byte_address,
                   output region_first, input ready);
   modport sink   (input valid, input data_byte, input byte_address,
                   input region_first, output ready);
endinterface

`default_nettype wire

// ===== design/scb_rsp_if.sv =====
// Result channel carrying the hit flags and start addresses.
`timescale 1ns / 1ps
`default_nettype none

interface scb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        short_hit;
   logic [scb_pkg::ADDR_W-1:0]  short_address;
   logic                        long_hit;
   logic [scb_pkg::ADDR_W-1:0]  long_address;

   modport source (output valid, output short_hit, output short_address,
                   output long_hit, output long_address, input ready);
   modport sink   (input valid, input short_hit, input short_address,
                   input long_hit, input long_address, output ready);
endinterface

`default_nettype wire

// ===== design/scb_csr_if.sv =====
// Configuration write channel with register index and write data.
`timescale 1ns / 1ps
`default_nettype none

interface scb_csr_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  index;
   logic [scb_pkg::ADDR_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/scb_cell.sv =====
// One cell of the byte window chain: holds a byte and its valid flag.
`timescale 1ns / 1ps
`default_nettype none

module scb_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              shift,
   input  wire logic              clear,
   input  wire scb_pkg::cell_type prev,
   output scb_pkg::cell_type      held
);

   scb_pkg::cell_type cell_ff;
   scb_pkg::cell_type cell_in;

   // A region start empties the cell instead of taking the neighbor's byte.
   always_comb begin
      cell_in.data  = prev.data;
      cell_in.valid = prev.valid && !clear;
   end

   // The valid flag is control state; the byte needs no reset.
   always_ff @(posedge clock) begin
      if (shift) begin
         cell_ff.data <= cell_in.data;
      end
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (shift) begin
         cell_ff.valid <= cell_in.valid;
      end
   end

   assign held = cell_ff;

endmodule

`default_nettype wire

// ===== design/scb_match.sv =====
// Decodes the window and tests the reference forms against the target.
`timescale 1ns / 1ps
`default_nettype none

module scb_match (
   input  scb_pkg::cell_type                  cells [scb_pkg::WIN_DEPTH],
   input  wire logic [scb_pkg::BYTE_W-1:0]    cur_byte,
   input  wire logic [scb_pkg::ADDR_W-1:0]    cur_address,
   input  wire logic                          first,
   input  wire scb_pkg::config_type           cfg,
   output scb_pkg::result_type                result
);

   logic [scb_pkg::OPND_W-1:0] operand;
   logic [scb_pkg::ADDR_W-1:0] dest;
   logic                       dest_eq64;
   logic                       dest_eq32;
   logic                       abs_eq;
   logic                       short_ok;
   logic                       long_ok;
   logic [scb_pkg::BYTE_W-1:0] short_op;
   logic [scb_pkg::BYTE_W-1:0] long_op0;
   logic [scb_pkg::BYTE_W-1:0] long_op1;
   logic                       short_hit;
   logic                       long_hit;

   // Both forms carry their operand in the last four bytes, little-endian.
   assign operand = {cur_byte, cells[0].data, cells[1].data, cells[2].data};

   // Start plus length is the address after the current byte for both forms.
   assign dest = cur_address + scb_pkg::ADDR_W'(1)
               + {{(scb_pkg::ADDR_W-scb_pkg::OPND_W){operand[scb_pkg::OPND_W-1]}}, operand};

   assign dest_eq64 = (dest == cfg.target_address);
   assign dest_eq32 = (dest[scb_pkg::OPND_W-1:0] == cfg.target_address[scb_pkg::OPND_W-1:0]);
   assign abs_eq    = (operand == cfg.target_address[scb_pkg::OPND_W-1:0]);

   // All bytes of a form must lie inside the current region.
   assign short_ok = cells[scb_pkg::SHORT_TAP].valid && !first;
   assign long_ok  = cells[scb_pkg::LONG_TAP].valid && !first;
   assign short_op = cells[scb_pkg::SHORT_TAP].data;
   assign long_op0 = cells[scb_pkg::LONG_TAP].data;
   assign long_op1 = cells[scb_pkg::LONG_TAP-1].data;

   // Five-byte forms.
   always_comb begin
      short_hit = 1'b0;
      if (short_ok) begin
         if (cfg.scan_kind == scb_pkg::KIND_FUNCTION) begin
            if (short_op inside {scb_pkg::OP_CALL_REL, scb_pkg::OP_JMP_REL}) begin
               short_hit = cfg.mode_32bit ? dest_eq32 : dest_eq64;
            end else if ((short_op inside {scb_pkg::OP_PUSH_IMM, scb_pkg::OP_CALL_FAR})
                         && cfg.mode_32bit) begin
               short_hit = abs_eq;
            end
         end else begin
            if ((short_op inside {scb_pkg::OP_MOV_EAX, scb_pkg::OP_MOV_ECX,
                                  scb_pkg::OP_MOV_EDX, scb_pkg::OP_PUSH_IMM})
                && cfg.mode_32bit) begin
               short_hit = abs_eq;
            end
         end
      end
   end

   // Seven-byte forms: RIP-relative LEA, or the 32-bit immediate move.
   always_comb begin
      long_hit = 1'b0;
      if (long_ok) begin
         if (long_op0 == scb_pkg::OP_REX_W && long_op1 == scb_pkg::OP_LEA
             && !cfg.mode_32bit) begin
            long_hit = dest_eq64;
         end else if (cfg.scan_kind == scb_pkg::KIND_STRING
                      && long_op0 == scb_pkg::OP_MOV_RM && cfg.mode_32bit) begin
            long_hit = abs_eq;
         end
      end
   end

   // Start addresses read zero when there is no hit.
   always_comb begin
      result.short_hit     = short_hit;
      result.short_address = short_hit ? cur_address - scb_pkg::ADDR_W'(4) : '0;
      result.long_hit      = long_hit;
      result.long_address  = long_hit ? cur_address - scb_pkg::ADDR_W'(6) : '0;
   end

endmodule

`default_nettype wire

// ===== design/scb_outq.sv =====
// Two-entry result queue that decouples the scanner from the result sink.
`timescale 1ns / 1ps
`default_nettype none

module scb_outq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire scb_pkg::result_type push_data,
   input  wire logic                pop_ready,
   output logic                     out_valid,
   output scb_pkg::result_type      out_data,
   output logic                     full
);

   scb_pkg::result_type entry_ff [2];
   logic                wr_ptr_ff;
   logic                wr_ptr_in;
   logic                rd_ptr_ff;
   logic                rd_ptr_in;
   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   logic                pop;

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = out_valid && pop_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/code_reference_scanner.sv =====
// Top level of the code reference scanner: window chain, matcher, result queue.
//
// The scanner takes one code byte per clock cycle while the result queue has
// room and returns one result per byte, in order. The six earlier bytes of the
// region ride in a chain of cells that shifts once per accepted transaction;
// a single 64-bit add and a 64- or 32-bit compare per byte test the relative
// forms, so the sustained rate is one byte per cycle while the sink keeps up.
// A two-entry result queue lets the input keep flowing while one result waits
// on the sink; input stalls only when both entries are full. Configuration
// writes are accepted at any time and should be made while no byte is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "code_reference_scanner_assert.svh"

module code_reference_scanner (
   input  wire logic clock,
   input  wire logic reset,
   scb_req_if.sink   req_if,
   scb_rsp_if.source rsp_if,
   scb_csr_if.sink   csr_if
);

   scb_pkg::config_type cfg_ff;
   scb_pkg::config_type cfg_in;
   scb_pkg::cell_type   cells    [scb_pkg::WIN_DEPTH];
   scb_pkg::cell_type   chain_in [scb_pkg::WIN_DEPTH];
   scb_pkg::result_type match_result;
   scb_pkg::result_type rsp_data;
   logic                req_accept;
   logic                queue_full;

   // Configuration registers; unknown indexes are ignored.
   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (scb_pkg::csr_index_type'(csr_if.index))
            scb_pkg::CSR_TARGET: cfg_in.target_address = csr_if.data;
            scb_pkg::CSR_MODE32: cfg_in.mode_32bit     = csr_if.data[0];
            scb_pkg::CSR_KIND:   cfg_in.scan_kind      = csr_if.data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input handshake.
   assign req_if.ready = !queue_full;
   assign req_accept   = req_if.valid && req_if.ready;

   // Window chain: the current byte enters cell zero, each cell feeds the next.
   assign chain_in[0] = '{valid: 1'b1, data: req_if.data_byte};

   genvar gi;
   generate
      for (gi = 0; gi < scb_pkg::WIN_DEPTH; gi++) begin : g_cell
         if (gi > 0) begin : g_link
            assign chain_in[gi] = cells[gi-1];
         end
         scb_cell u_cell (
            .clock (clock),
            .reset (reset),
            .shift (req_accept),
            .clear ((gi > 0) ? req_if.region_first : 1'b0),
            .prev  (chain_in[gi]),
            .held  (cells[gi])
         );
      end
   endgenerate

   // Form decode and target compare.
   scb_match u_match (
      .cells       (cells),
      .cur_byte    (req_if.data_byte),
      .cur_address (req_if.byte_address),
      .first       (req_if.region_first),
      .cfg         (cfg_ff),
      .result      (match_result)
   );

   // Result queue.
   scb_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (match_result),
      .pop_ready (rsp_if.ready),
      .out_valid (rsp_if.valid),
      .out_data  (rsp_data),
      .full      (queue_full)
   );

   assign rsp_if.short_hit     = rsp_data.short_hit;
   assign rsp_if.short_address = rsp_data.short_address;
   assign rsp_if.long_hit      = rsp_data.long_hit;
   assign rsp_if.long_address  = rsp_data.long_address;

   // Every accepted byte leaves a result ready in the next cycle.
   `SCB_ASSERT_NEXT(a_result_follows, clock, reset, req_accept, rsp_if.valid)
   // A region start leaves only the newest byte in the window.
   `SCB_ASSERT_NEXT(a_region_clears, clock, reset, req_accept && req_if.region_first,
                    cells[0].valid && !cells[1].valid && !cells[scb_pkg::LONG_TAP].valid)
   // Once the window is full inside a region it stays full.
   `SCB_ASSERT_NEXT(a_window_holds, clock, reset,
                    req_accept && !req_if.region_first && cells[scb_pkg::LONG_TAP-1].valid,
                    cells[scb_pkg::LONG_TAP].valid)
   // Start addresses read zero on a miss.
   `SCB_ASSERT_IMPL(a_short_zero, clock, reset, rsp_if.valid && !rsp_if.short_hit,
                    rsp_if.short_address == '0)
   `SCB_ASSERT_IMPL(a_long_zero, clock, reset, rsp_if.valid && !rsp_if.long_hit,
                    rsp_if.long_address == '0)

endmodule

`default_nettype wire
